### hdl/pmfs_pkg.sv
// ----------------------------------------------------------------------------
// pmfs_pkg
// Shared types and constants of the page mapper with its free frame stack.
// ----------------------------------------------------------------------------
`default_nettype none

package pmfs_pkg;

  localparam int FRAME_SLOTS   = 4096;
  localparam int TABLE_ENTRIES = 1024;

  localparam int FRAME_AW = $clog2(FRAME_SLOTS);
  localparam int COUNT_W  = $clog2(FRAME_SLOTS + 1);
  localparam int PAGE_AW  = $clog2(TABLE_ENTRIES);

  localparam int FRAME_W = 20;
  localparam int FLAG_W  = 12;
  localparam int ENTRY_W = FRAME_W + FLAG_W;
  localparam int MODE_W  = 2;
  localparam int INDEX_W = 10;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 2'd0,
    MODE_MAP    = 2'd1,
    MODE_MAP_AT = 2'd2,
    MODE_UNMAP  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MAPPED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } fsm_t;

endpackage

`default_nettype wire

### hdl/page_mapper_with_frame_stack.sv
// ----------------------------------------------------------------------------
// page_mapper_with_frame_stack
// Free frame stack plus one page table; push, map, map-at and unmap words.
// ----------------------------------------------------------------------------
// Flow: a word is latched and both memories read on accept, its result is
//   decided in execute and registered on commit; a stalled result holds the
//   next word in execute until it drains. One word at a time: in_ready is
//   low in execute, for the read-then-write pass (read on accept, write in
//   execute). Reset: the stack count clears at once; the page table is then
//   swept to zero, one entry a cycle over 1024 entries, with in_ready low.
`default_nettype none

module page_mapper_with_frame_stack
  import pmfs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [MODE_W-1:0]  mode,
  input  wire logic [INDEX_W-1:0] page_index,
  input  wire logic [FRAME_W-1:0] frame_number,
  input  wire logic [FLAG_W-1:0]  entry_flags,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output logic [FRAME_W-1:0]      frame_used,
  output logic [FLAG_W-1:0]       old_flags
);

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  fsm_t                state, state_next;
  logic [PAGE_AW-1:0]  clr_addr;
  logic [COUNT_W-1:0]  count, count_next;

  // Latched input word
  mode_t               op_mode;
  logic [PAGE_AW-1:0]  op_index;
  logic [FRAME_W-1:0]  op_frame;
  logic [FLAG_W-1:0]   op_flags;

  // Memories: page table and free frame stack, both read through a register
  logic [ENTRY_W-1:0]  pt_mem [TABLE_ENTRIES];
  logic [FRAME_W-1:0]  stk_mem [FRAME_SLOTS];
  logic [ENTRY_W-1:0]  pt_rdata;
  logic [FRAME_W-1:0]  stk_rdata;

  logic                pt_we;
  logic [PAGE_AW-1:0]  pt_waddr;
  logic [ENTRY_W-1:0]  pt_wdata;
  logic                stk_we;
  logic [FRAME_W-1:0]  stk_wdata;

  // Handshake terms
  logic                accept;
  logic                commit;
  logic                clr_last;

  // Result of the execute cycle
  status_t             res_status;
  logic [FRAME_W-1:0]  res_frame;
  logic [FLAG_W-1:0]   res_flags;

  logic                present;
  logic                stk_full;
  logic                stk_empty;
  logic [COUNT_W-1:0]  count_m1;

  assign accept   = in_valid && in_ready;
  // Execute finishes only when the output register is free or draining.
  assign commit   = (state == S_EXEC) && (!out_valid || out_ready);
  assign clr_last = (clr_addr == PAGE_AW'(TABLE_ENTRIES - 1));

  assign present   = pt_rdata[0];
  assign stk_full  = (count == COUNT_W'(FRAME_SLOTS));
  assign stk_empty = (count == '0);
  assign count_m1  = count - COUNT_W'(1);

  // --------------------------------------------------------------------------
  // FSM: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_last) state_next = S_IDLE;
      S_IDLE:  if (accept)   state_next = S_EXEC;
      S_EXEC:  if (commit)   state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // FSM: outputs
  always_comb begin
    in_ready = (state == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + PAGE_AW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Input latch
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode  <= mode_t'(mode);
      // table depth is a power of two: modulo is the low bits
      op_index <= page_index[PAGE_AW-1:0];
      op_frame <= frame_number;
      op_flags <= entry_flags;
    end
  end

  // --------------------------------------------------------------------------
  // Execute: decide result and memory writes from the read data
  // --------------------------------------------------------------------------
  always_comb begin
    res_status = ST_OK;
    res_frame  = '0;
    res_flags  = '0;
    count_next = count;
    stk_we     = 1'b0;
    stk_wdata  = op_frame;
    pt_we      = 1'b0;
    pt_waddr   = op_index;
    pt_wdata   = '0;

    if (state == S_CLEAR) begin
      pt_we    = 1'b1;
      pt_waddr = clr_addr;
    end else if (commit) begin
      unique case (op_mode)
        MODE_PUSH: begin
          if (stk_full) begin
            res_status = ST_FULL;
          end else begin
            stk_we     = 1'b1;
            count_next = count + COUNT_W'(1);
            res_frame  = op_frame;
          end
        end
        MODE_MAP, MODE_MAP_AT: begin
          if (present) begin
            res_status = ST_MAPPED;
          end else if (op_mode == MODE_MAP && stk_empty) begin
            res_status = ST_EMPTY;
          end else begin
            if (op_mode == MODE_MAP) begin
              res_frame  = stk_rdata;
              count_next = count_m1;
            end else begin
              res_frame = op_frame;
            end
            pt_we    = 1'b1;
            pt_wdata = {res_frame, op_flags | FLAG_W'(1)};
          end
        end
        MODE_UNMAP: begin
          res_flags = pt_rdata[FLAG_W-1:0];
          pt_we     = 1'b1;  // entry always cleared
          if (present) begin
            res_frame = pt_rdata[ENTRY_W-1:FLAG_W];
            stk_wdata = pt_rdata[ENTRY_W-1:FLAG_W];
            if (stk_full) begin
              res_status = ST_FULL;  // released frame is dropped
            end else begin
              stk_we     = 1'b1;
              count_next = count + COUNT_W'(1);
            end
          end
        end
        default: res_status = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // --------------------------------------------------------------------------
  // Page table memory
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
    if (accept) pt_rdata <= pt_mem[page_index[PAGE_AW-1:0]];
  end

  // --------------------------------------------------------------------------
  // Free frame stack memory; top of stack read on accept
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[count[FRAME_AW-1:0]] <= stk_wdata;
    if (accept) stk_rdata <= stk_mem[count_m1[FRAME_AW-1:0]];
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status     <= res_status;
      frame_used <= res_frame;
      old_flags  <= res_flags;
    end
  end

endmodule

`default_nettype wire

### hdl/pmfs_checker.sv
// ----------------------------------------------------------------------------
// pmfs_checker
// Port-level checks of the page mapper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pmfs_checker
  import pmfs_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [1:0]         status,
  input wire logic [FRAME_W-1:0] frame_used,
  input wire logic [FLAG_W-1:0]  old_flags
);

  // Reset starts the clearing sweep with both channels quiet.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("channels active right after reset");

  // One word in flight: no accept in the cycle after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in flight");

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status)
      && $stable(frame_used) && $stable(old_flags))
    else $error("stalled result changed");

  // Refused maps report no frame and no flags.
  a_refused_map: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_MAPPED || status == ST_EMPTY)
      |-> frame_used == '0 && old_flags == '0)
    else $error("refused map reports a frame or flags");

endmodule

bind page_mapper_with_frame_stack pmfs_checker u_pmfs_checker (.*);

`default_nettype wire
